### sv/egrb_pkg.sv
// ----------------------------------------------------------------------------
// egrb_pkg
// Types and constants shared by the edge graph relative bound unit.
// ----------------------------------------------------------------------------
`default_nettype none

package egrb_pkg;

    localparam int BOUND_W   = 48;
    localparam int EPOCH_W   = 8;
    localparam int DIV_STEPS = 48;
    localparam int CFG_W     = 32;
    localparam int VERT_W    = 10;
    localparam int SLOT_W    = 12;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam logic [0:0] CFG_EPS_SQ   = 1'b0;
    localparam logic [0:0] CFG_RATIO_SQ = 1'b1;

    localparam logic [23:0] RATIO_RESET = 24'h01_0000;

    localparam logic [BOUND_W-1:0] BOUND_INF = 48'hFFFF_FFFF_FFFF;
    localparam logic [BOUND_W-1:0] BOUND_SAT = 48'hFFFF_FFFF_FFFE;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD_MUL,
        ST_LOAD_CHK,
        ST_LOAD_DIV,
        ST_LOAD_WU,
        ST_LOAD_WV,
        ST_QRY_MUL,
        ST_QRY_OUT
    } state_t;

    typedef struct packed {
        logic              en;
        logic [VERT_W-1:0] addr;
        logic              flag;
    } flag_wr_t;

    function automatic logic [31:0] mag32(input logic [31:0] x);
        logic [31:0] n;
        n = x[31] ? (~x + 32'd1) : x;
        return n;
    endfunction

    // low 32 bits of |a - b|; the magnitude always fits in 32 bits
    function automatic logic [31:0] diff_mag(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] d;
        d = {a[31], a} - {b[31], b};
        if (d[32])
        begin
            d = ~d + 33'd1;
        end
        return d[31:0];
    endfunction

endpackage

`default_nettype wire

### sv/egrb_in_if.sv
// ----------------------------------------------------------------------------
// egrb_in_if
// Input channel: one edge command item with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface egrb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [11:0] edge_index;
    logic [9:0]  vert_u;
    logic [9:0]  vert_v;
    logic signed [31:0] target_dx;
    logic signed [31:0] target_dy;
    logic signed [31:0] source_dx;
    logic signed [31:0] source_dy;
    logic signed [31:0] dir_u_x;
    logic signed [31:0] dir_u_y;
    logic signed [31:0] dir_v_x;
    logic signed [31:0] dir_v_y;

    modport source (
        output valid, mode, edge_index, vert_u, vert_v, target_dx, target_dy,
               source_dx, source_dy, dir_u_x, dir_u_y, dir_v_x, dir_v_y,
        input  ready
    );
    modport sink (
        input  valid, mode, edge_index, vert_u, vert_v, target_dx, target_dy,
               source_dx, source_dy, dir_u_x, dir_u_y, dir_v_x, dir_v_y,
        output ready
    );
endinterface

`default_nettype wire

### sv/egrb_out_if.sv
// ----------------------------------------------------------------------------
// egrb_out_if
// Output channel: one query result item with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface egrb_out_if;
    logic       valid;
    logic       ready;
    logic       keep;
    logic [9:0] vert_high;
    logic [9:0] vert_low;
    logic       both_stationary;

    modport source (
        output valid, keep, vert_high, vert_low, both_stationary,
        input  ready
    );
    modport sink (
        input  valid, keep, vert_high, vert_low, both_stationary,
        output ready
    );
endinterface

`default_nettype wire

### sv/egrb_flag_ram.sv
// ----------------------------------------------------------------------------
// egrb_flag_ram
// Per-vertex stationary flags, tagged with a graph epoch so that a new graph
// needs no sweep except when the epoch wraps.
// ----------------------------------------------------------------------------
`default_nettype none

module egrb_flag_ram #(
    parameter int DEPTH = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire egrb_pkg::flag_wr_t wr,
    input  wire logic               rd_en,
    input  wire logic [9:0]         rd_addr_a,
    input  wire logic [9:0]         rd_addr_b,
    input  wire logic               new_graph,
    output logic                    flag_a,
    output logic                    flag_b,
    output logic                    epoch_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [egrb_pkg::EPOCH_W:0]   mem [DEPTH];
    logic [egrb_pkg::EPOCH_W:0]   rd_a_reg;
    logic [egrb_pkg::EPOCH_W:0]   rd_b_reg;
    logic [egrb_pkg::EPOCH_W-1:0] epoch_reg;
    logic [egrb_pkg::EPOCH_W-1:0] epoch_next;

    assign epoch_next = new_graph ? epoch_reg + 1'b1 : epoch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg <= '0;
        end
        else
        begin
            epoch_reg <= epoch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr[AW-1:0]] <= {epoch_reg, wr.flag};
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a[AW-1:0]];
            rd_b_reg <= mem[rd_addr_b[AW-1:0]];
        end
    end

    // a flag from an older graph reads as clear
    assign flag_a     = rd_a_reg[0] && (rd_a_reg[egrb_pkg::EPOCH_W:1] == epoch_reg);
    assign flag_b     = rd_b_reg[0] && (rd_b_reg[egrb_pkg::EPOCH_W:1] == epoch_reg);
    assign epoch_last = (epoch_reg == '1);

endmodule

`default_nettype wire

### sv/egrb_bound_ram.sv
// ----------------------------------------------------------------------------
// egrb_bound_ram
// Per-edge bound store, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module egrb_bound_ram #(
    parameter int DEPTH = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          we,
    input  wire logic [11:0]                   waddr,
    input  wire logic [egrb_pkg::BOUND_W-1:0]  wdata,
    input  wire logic                          re,
    input  wire logic [11:0]                   raddr,
    output logic      [egrb_pkg::BOUND_W-1:0]  rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [egrb_pkg::BOUND_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr[AW-1:0]] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr[AW-1:0]];
        end
    end

endmodule

`default_nettype wire

### sv/egrb_mul32.sv
// ----------------------------------------------------------------------------
// egrb_mul32
// Shared 32x32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module egrb_mul32 (
    input  wire logic        clk,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [63:0] p
);

    always_ff @(posedge clk)
    begin
        p <= 64'(a) * 64'(b);
    end

endmodule

`default_nettype wire

### sv/egrb_div.sv
// ----------------------------------------------------------------------------
// egrb_div
// Restoring divider: 48 quotient bits of num / (x * 2^16), one bit a cycle.
// Caller guarantees the quotient fits in 48 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module egrb_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [127:0]                 num,
    input  wire logic [63:0]                  den_x,
    output logic                              done,
    output logic [egrb_pkg::BOUND_W-1:0]      q
);

    logic [127:0] rem_reg, rem_next;
    logic [127:0] d_reg, d_next;
    logic [egrb_pkg::BOUND_W-1:0] q_reg, q_next;
    logic [5:0]   cnt_reg, cnt_next;
    logic         run_reg, run_next;
    logic         done_reg, done_next;

    always_comb
    begin
        rem_next  = rem_reg;
        d_next    = d_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = num;
            // divisor x*2^16 aligned to the top quotient bit
            d_next   = 128'({den_x, 63'd0});
            q_next   = '0;
            cnt_next = 6'(egrb_pkg::DIV_STEPS - 1);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (rem_reg >= d_reg)
            begin
                rem_next = rem_reg - d_reg;
                q_next   = {q_reg[egrb_pkg::BOUND_W-2:0], 1'b1};
            end
            else
            begin
                q_next   = {q_reg[egrb_pkg::BOUND_W-2:0], 1'b0};
            end
            d_next = d_reg >> 1;
            if (cnt_reg == 6'd0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        d_reg   <= d_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

`default_nettype wire

### sv/edge_graph_relative_bound_unit.sv
// ----------------------------------------------------------------------------
// edge_graph_relative_bound_unit
// Loads mesh edges, keeps per-edge bounds and a running maximum, answers
// keep/drop queries.
//
// in_ch carries commands: start graph, load edge, query edge. out_ch carries
// one item per query. Config writes (cfg_we/cfg_index/cfg_data) land at once.
// One item is worked on at a time; in_ch.ready is high only when idle.
//   start : handled in idle; every 256th start sweeps the flag memory.
//   load  : LOAD_MUL on the shared 32x32 multiplier (14 products), LOAD_CHK,
//           the bit-serial divider in LOAD_DIV if needed, LOAD_WU, LOAD_WV.
//   query : memory read, two multiplier passes for ratio_sq * max, compare,
//           then the result is registered in the output register.
// After reset the flag memory is swept, one entry a cycle, over all
// min(MAX_VERTS,1024) entries, with in_ch.ready low; config writes still land.
// A result waits in the output register while out_ch.ready is low; the next
// command is taken meanwhile and a further query holds until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module edge_graph_relative_bound_unit #(
    parameter int MAX_EDGES = 4096,
    parameter int MAX_VERTS = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    egrb_in_if.sink          in_ch,
    egrb_out_if.source       out_ch
);

    localparam int EDEPTH = (MAX_EDGES < 4096) ? MAX_EDGES : 4096;
    localparam int VDEPTH = (MAX_VERTS < 1024) ? MAX_VERTS : 1024;
    localparam int VAW    = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;

    egrb_pkg::state_t state_reg, state_next;

    logic [4:0]  step_reg, step_next;
    logic [31:0] eps_reg;
    logic [23:0] ratio_reg;
    logic [11:0] slot_reg;
    logic [9:0]  u_reg, v_reg;
    logic        u_ok_reg, v_ok_reg, slot_ok_reg;
    logic [9:0][31:0] mag_reg;
    logic [63:0] nu_reg, nu_next, nv_reg, nv_next;
    logic [63:0] y_reg, y_next, x_reg, x_next;
    logic [63:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [64:0] s_reg, s_next;
    logic [127:0] num_reg, num_next;
    logic        su_reg, su_next, sv_reg, sv_next;
    logic [egrb_pkg::BOUND_W-1:0] bound_reg, bound_next;
    logic [egrb_pkg::BOUND_W-1:0] bmax_reg, bmax_next;
    logic        max_valid_reg, max_valid_next;
    logic [VAW-1:0] clr_idx_reg, clr_idx_next;
    logic        out_valid_reg, out_valid_next;
    logic        keep_reg, keep_next;
    logic [9:0]  vh_reg, vh_next, vl_reg, vl_next;
    logic        bs_reg, bs_next;

    logic        accept;
    logic        clr_last;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic        div_start, div_done;
    logic [egrb_pkg::BOUND_W-1:0] div_q;
    logic [63:0] thr;
    logic        su_c, sv_c;
    logic        fu, fv;
    logic [egrb_pkg::BOUND_W-1:0] qbound, ram_rdata;
    logic        keep_c;
    logic        new_graph;
    logic        epoch_last;
    egrb_pkg::flag_wr_t flag_wr;
    logic        bram_we;

    function automatic logic fu_g();
        return fu && u_ok_reg;
    endfunction

    function automatic logic fv_g();
        return fv && v_ok_reg;
    endfunction

    assign accept   = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == egrb_pkg::ST_IDLE);
    assign clr_last = (clr_idx_reg == VAW'(VDEPTH - 1));
    assign new_graph = accept && (in_ch.mode == egrb_pkg::MODE_START);

    // ---------------- config ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg   <= '0;
            ratio_reg <= egrb_pkg::RATIO_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                egrb_pkg::CFG_EPS_SQ:   eps_reg   <= cfg_data;
                egrb_pkg::CFG_RATIO_SQ: ratio_reg <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // ---------------- item capture ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg    <= in_ch.edge_index;
            u_reg       <= in_ch.vert_u;
            v_reg       <= in_ch.vert_v;
            u_ok_reg    <= ({22'd0, in_ch.vert_u} < 32'(MAX_VERTS));
            v_ok_reg    <= ({22'd0, in_ch.vert_v} < 32'(MAX_VERTS));
            slot_ok_reg <= ({20'd0, in_ch.edge_index} < 32'(MAX_EDGES));
            mag_reg[0]  <= egrb_pkg::mag32(in_ch.dir_u_x);
            mag_reg[1]  <= egrb_pkg::mag32(in_ch.dir_u_y);
            mag_reg[2]  <= egrb_pkg::mag32(in_ch.dir_v_x);
            mag_reg[3]  <= egrb_pkg::mag32(in_ch.dir_v_y);
            mag_reg[4]  <= egrb_pkg::mag32(in_ch.source_dx);
            mag_reg[5]  <= egrb_pkg::mag32(in_ch.source_dy);
            mag_reg[6]  <= egrb_pkg::mag32(in_ch.target_dx);
            mag_reg[7]  <= egrb_pkg::mag32(in_ch.target_dy);
            mag_reg[8]  <= egrb_pkg::diff_mag(in_ch.dir_u_x, in_ch.dir_v_x);
            mag_reg[9]  <= egrb_pkg::diff_mag(in_ch.dir_u_y, in_ch.dir_v_y);
        end
    end

    // ---------------- units ----------------
    egrb_mul32 u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    egrb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den_x (x_reg),
        .done  (div_done),
        .q     (div_q)
    );

    egrb_flag_ram #(.DEPTH(VDEPTH)) u_flags (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (flag_wr),
        .rd_en      (accept && (in_ch.mode == egrb_pkg::MODE_QUERY)),
        .rd_addr_a  (in_ch.vert_u),
        .rd_addr_b  (in_ch.vert_v),
        .new_graph  (new_graph),
        .flag_a     (fu),
        .flag_b     (fv),
        .epoch_last (epoch_last)
    );

    egrb_bound_ram #(.DEPTH(EDEPTH)) u_bounds (
        .clk   (clk),
        .we    (bram_we),
        .waddr (slot_reg),
        .wdata (bound_reg),
        .re    (accept && (in_ch.mode == egrb_pkg::MODE_QUERY)),
        .raddr (in_ch.edge_index),
        .rdata (ram_rdata)
    );

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            egrb_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = egrb_pkg::ST_IDLE;
                end
            end
            egrb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_ch.mode)
                        egrb_pkg::MODE_START:
                            state_next = epoch_last ? egrb_pkg::ST_CLEAR : egrb_pkg::ST_IDLE;
                        egrb_pkg::MODE_LOAD:  state_next = egrb_pkg::ST_LOAD_MUL;
                        egrb_pkg::MODE_QUERY: state_next = egrb_pkg::ST_QRY_MUL;
                        default:              state_next = egrb_pkg::ST_IDLE;
                    endcase
                end
            end
            egrb_pkg::ST_LOAD_MUL:
            begin
                if (step_reg == 5'd16)
                begin
                    state_next = egrb_pkg::ST_LOAD_CHK;
                end
            end
            egrb_pkg::ST_LOAD_CHK:
            begin
                if (su_c != sv_c || x_reg == 64'd0 || num_reg[127:64] >= x_reg)
                begin
                    state_next = egrb_pkg::ST_LOAD_WU;
                end
                else
                begin
                    state_next = egrb_pkg::ST_LOAD_DIV;
                end
            end
            egrb_pkg::ST_LOAD_DIV:
            begin
                if (div_done)
                begin
                    state_next = egrb_pkg::ST_LOAD_WU;
                end
            end
            egrb_pkg::ST_LOAD_WU: state_next = egrb_pkg::ST_LOAD_WV;
            egrb_pkg::ST_LOAD_WV: state_next = egrb_pkg::ST_IDLE;
            egrb_pkg::ST_QRY_MUL:
            begin
                if (step_reg == 5'd2)
                begin
                    state_next = egrb_pkg::ST_QRY_OUT;
                end
            end
            egrb_pkg::ST_QRY_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    state_next = egrb_pkg::ST_IDLE;
                end
            end
            default: state_next = egrb_pkg::ST_IDLE;
        endcase
    end

    // ---------------- query decision ----------------
    assign thr    = {16'd0, eps_reg, 16'd0};
    assign su_c   = nu_reg < thr;
    assign sv_c   = nv_reg < thr;
    assign qbound = slot_ok_reg ? ram_rdata : '0;

    always_comb
    begin
        keep_c = 1'b0;
        if (fu_g() && fv_g())
        begin
            keep_c = 1'b1;
        end
        else if (!fu_g() && !fv_g() && max_valid_reg && qbound != egrb_pkg::BOUND_INF)
        begin
            if (bmax_reg == egrb_pkg::BOUND_INF)
            begin
                keep_c = (ratio_reg != 24'd0);
            end
            else
            begin
                keep_c = ({8'd0, qbound, 16'd0} < num_reg[71:0]);
            end
        end
    end

    // ---------------- outputs and datapath ----------------
    always_comb
    begin
        step_next      = step_reg;
        nu_next        = nu_reg;
        nv_next        = nv_reg;
        y_next         = y_reg;
        x_next         = x_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        s_next         = s_reg;
        num_next       = num_reg;
        su_next        = su_reg;
        sv_next        = sv_reg;
        bound_next     = bound_reg;
        bmax_next      = bmax_reg;
        max_valid_next = max_valid_reg;
        clr_idx_next   = clr_idx_reg;
        keep_next      = keep_reg;
        vh_next        = vh_reg;
        vl_next        = vl_reg;
        bs_next        = bs_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;
        flag_wr        = '0;
        bram_we        = 1'b0;

        unique case (state_reg)
            egrb_pkg::ST_CLEAR:
            begin
                flag_wr.en   = 1'b1;
                flag_wr.addr = 10'(clr_idx_reg);
                flag_wr.flag = 1'b0;
                clr_idx_next = clr_idx_reg + 1'b1;
            end
            egrb_pkg::ST_IDLE:
            begin
                step_next = '0;
                if (new_graph)
                begin
                    bmax_next      = '0;
                    max_valid_next = 1'b0;
                    clr_idx_next   = '0;
                end
            end
            egrb_pkg::ST_LOAD_MUL:
            begin
                step_next = step_reg + 5'd1;
                // operands issued this step
                unique case (step_reg)
                    5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9:
                    begin
                        mul_a = mag_reg[step_reg[3:0]];
                        mul_b = mag_reg[step_reg[3:0]];
                    end
                    5'd12:
                    begin
                        mul_a = s_reg[31:0];
                        mul_b = y_reg[31:0];
                    end
                    5'd13:
                    begin
                        mul_a = s_reg[31:0];
                        mul_b = y_reg[63:32];
                    end
                    5'd14:
                    begin
                        mul_a = s_reg[63:32];
                        mul_b = y_reg[31:0];
                    end
                    5'd15:
                    begin
                        mul_a = s_reg[63:32];
                        mul_b = y_reg[63:32];
                    end
                    default: ;
                endcase
                // product of the previous step
                unique case (step_reg)
                    5'd1:  nu_next = prod;
                    5'd2:  nu_next = nu_reg + prod;
                    5'd3:  nv_next = prod;
                    5'd4:  nv_next = nv_reg + prod;
                    5'd5:  y_next  = prod;
                    5'd6:  y_next  = y_reg + prod;
                    5'd7:  x_next  = prod;
                    5'd8:  x_next  = x_reg + prod;
                    5'd9:  dx_next = prod;
                    5'd10: dy_next = prod;
                    5'd11: s_next  = {1'b0, dx_reg} + {1'b0, dy_reg};
                    5'd12: num_next = s_reg[64] ? {y_reg, 64'd0} : 128'd0;
                    5'd13: num_next = num_reg + {64'd0, prod};
                    5'd14: num_next = num_reg + {32'd0, prod, 32'd0};
                    5'd15: num_next = num_reg + {32'd0, prod, 32'd0};
                    5'd16: num_next = num_reg + {prod, 64'd0};
                    default: ;
                endcase
            end
            egrb_pkg::ST_LOAD_CHK:
            begin
                su_next = su_c;
                sv_next = sv_c;
                if (su_c != sv_c)
                begin
                    bound_next = '0;
                end
                else if (x_reg == 64'd0)
                begin
                    bound_next = egrb_pkg::BOUND_INF;
                end
                else if (num_reg[127:64] >= x_reg)
                begin
                    bound_next = egrb_pkg::BOUND_SAT;
                end
                else
                begin
                    div_start = 1'b1;
                end
            end
            egrb_pkg::ST_LOAD_DIV:
            begin
                if (div_done)
                begin
                    bound_next = (div_q == egrb_pkg::BOUND_INF) ? egrb_pkg::BOUND_SAT : div_q;
                end
            end
            egrb_pkg::ST_LOAD_WU:
            begin
                flag_wr.en   = u_ok_reg;
                flag_wr.addr = u_reg;
                flag_wr.flag = su_reg;
                bram_we      = slot_ok_reg;
                if (su_reg == sv_reg && (!max_valid_reg || bound_reg > bmax_reg))
                begin
                    bmax_next      = bound_reg;
                    max_valid_next = 1'b1;
                end
            end
            egrb_pkg::ST_LOAD_WV:
            begin
                flag_wr.en   = v_ok_reg;
                flag_wr.addr = v_reg;
                flag_wr.flag = sv_reg;
            end
            egrb_pkg::ST_QRY_MUL:
            begin
                step_next = step_reg + 5'd1;
                mul_a     = {8'd0, ratio_reg};
                unique case (step_reg)
                    5'd0: mul_b = bmax_reg[31:0];
                    5'd1:
                    begin
                        mul_b    = {16'd0, bmax_reg[47:32]};
                        num_next = {64'd0, prod};
                    end
                    5'd2: num_next = num_reg + {32'd0, prod, 32'd0};
                    default: ;
                endcase
            end
            egrb_pkg::ST_QRY_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    keep_next      = keep_c;
                    vh_next        = (u_reg > v_reg) ? u_reg : v_reg;
                    vl_next        = (u_reg > v_reg) ? v_reg : u_reg;
                    bs_next        = fu_g() && fv_g();
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= egrb_pkg::ST_CLEAR;
            step_reg      <= '0;
            clr_idx_reg   <= '0;
            max_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            clr_idx_reg   <= clr_idx_next;
            max_valid_reg <= max_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nu_reg    <= nu_next;
        nv_reg    <= nv_next;
        y_reg     <= y_next;
        x_reg     <= x_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        s_reg     <= s_next;
        num_reg   <= num_next;
        su_reg    <= su_next;
        sv_reg    <= sv_next;
        bound_reg <= bound_next;
        bmax_reg  <= bmax_next;
        keep_reg  <= keep_next;
        vh_reg    <= vh_next;
        vl_reg    <= vl_next;
        bs_reg    <= bs_next;
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.keep            = keep_reg;
    assign out_ch.vert_high       = vh_reg;
    assign out_ch.vert_low        = vl_reg;
    assign out_ch.both_stationary = bs_reg;

endmodule

`default_nettype wire

### sv/egrb_checker.sv
// ----------------------------------------------------------------------------
// egrb_checker
// Port-level checks on the edge graph relative bound unit.
// ----------------------------------------------------------------------------
`default_nettype none

module egrb_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic [1:0] in_mode,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       keep,
    input wire logic [9:0] vert_high,
    input wire logic [9:0] vert_low,
    input wire logic       both_stationary
);

    // a waiting result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(vert_high) && $stable(keep))
        else $error("result item changed while stalled");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> vert_high >= vert_low)
        else $error("endpoint order wrong");

    a_stat_keep: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && both_stationary |-> keep)
        else $error("stationary edge dropped");

    // only a query item makes a result
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_mode != egrb_pkg::MODE_QUERY |=> !$rose(out_valid))
        else $error("result without a query");

endmodule

bind edge_graph_relative_bound_unit egrb_checker u_egrb_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_mode         (in_ch.mode),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .keep            (out_ch.keep),
    .vert_high       (out_ch.vert_high),
    .vert_low        (out_ch.vert_low),
    .both_stationary (out_ch.both_stationary)
);

`default_nettype wire
